// File: sv/idle_state_selector_assert.svh
`ifndef IDLE_STATE_SELECTOR_ASSERT_SVH
`define IDLE_STATE_SELECTOR_ASSERT_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define ISS_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("idle_state_selector check failed");

// next-cycle implication, sampled on clk, off while rst_n is low
`define ISS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("idle_state_selector check failed");

`endif

// File: sv/iss_pkg.sv
package iss_pkg;

    typedef enum logic [1:0] {
        CMD_ADD  = 2'd0,
        CMD_PICK = 2'd1,
        CMD_RES  = 2'd2
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_FULL = 2'd1,
        ST_NONE = 2'd2,
        ST_BAD  = 2'd3
    } status_t;

    localparam int ChosenWidth = 3;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic step;
        logic finish;
    } ctrl_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic is_pick;
        logic scan_last;
    } dp_status_t;

endpackage

// File: sv/idle_state_selector.sv
// operation: start is taken into RUN; pick scans every table slot there before its result, add and
//   residency finish without a scan; done marks the result for one cycle
// flow: one item at a time, a pick bounded by the one-slot-a-cycle table scan; a new
//   start is taken in the done cycle, never while busy
// reset: rst_n clears the controller and every valid mark at once, no clearing pass
module idle_state_selector
    import iss_pkg::*;
#(
    parameter int SLOT_COUNT = 8
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  command,
    input  logic [31:0] exit_latency,
    input  logic [31:0] predicted_idle,
    input  logic [3:0]  slot,
    input  logic [63:0] duration,
    output logic        done,
    output logic [1:0]  status,
    output logic [2:0]  chosen_slot,
    output logic [63:0] residency_total
);

`include "idle_state_selector_assert.svh"

    localparam int SW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

    ctrl_cmd_t  cmd;
    dp_status_t dp_st;

    iss_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .dp_st (dp_st),
        .cmd   (cmd),
        .busy  (busy),
        .done  (done)
    );

    iss_dp #(
        .SLOT_COUNT (SLOT_COUNT),
        .SW         (SW)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .dp_st           (dp_st),
        .command         (command),
        .exit_latency    (exit_latency),
        .predicted_idle  (predicted_idle),
        .slot            (slot),
        .duration        (duration),
        .status          (status),
        .chosen_slot     (chosen_slot),
        .residency_total (residency_total)
    );

    `ISS_ASSERT_NOW(a_done_not_busy, done, !busy)
    `ISS_ASSERT_NEXT(a_start_goes_busy, start && !busy, busy)
    `ISS_ASSERT_NEXT(a_done_single, done, !done)
    `ISS_ASSERT_NOW(a_fail_zero, done && (status != ST_OK), {chosen_slot, residency_total} == '0)

endmodule

// File: sv/iss_ctrl.sv
module iss_ctrl
    import iss_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  dp_status_t dp_st,
    output ctrl_cmd_t  cmd,
    output logic       busy,
    output logic       done
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_RUN  = 3'b010,
        S_DONE = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign busy = (state_reg == S_RUN);
    assign done = (state_reg == S_DONE);

    always_comb
    begin
        cmd.load   = start && !busy;
        cmd.step   = (state_reg == S_RUN);
        // non-pick commands finish on their first step, a pick after the last slot
        cmd.finish = cmd.step && (!dp_st.is_pick || dp_st.scan_last);
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (cmd.load)
                    state_next = S_RUN;
            end
            S_RUN:
            begin
                if (cmd.finish)
                    state_next = S_DONE;
            end
            S_DONE:
            begin
                if (cmd.load)
                    state_next = S_RUN;
                else
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

// File: sv/iss_dp.sv
module iss_dp
    import iss_pkg::*;
#(
    parameter int SLOT_COUNT = 8,
    parameter int SW         = 3
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  ctrl_cmd_t              cmd,
    output dp_status_t             dp_st,
    input  logic [1:0]             command,
    input  logic [31:0]            exit_latency,
    input  logic [31:0]            predicted_idle,
    input  logic [3:0]             slot,
    input  logic [63:0]            duration,
    output logic [1:0]             status,
    output logic [ChosenWidth-1:0] chosen_slot,
    output logic [63:0]            residency_total
);

    // table
    logic [SLOT_COUNT-1:0] valid_reg;
    logic [31:0]           lat_mem [SLOT_COUNT];
    logic [63:0]           res_mem [SLOT_COUNT];

    // latched item
    logic [1:0]  cmd_reg;
    logic [31:0] lat_in_reg;
    logic [31:0] idle_reg;
    logic [3:0]  slot_reg;
    logic [63:0] dur_reg;

    // scan state
    logic [SW-1:0] ptr_reg;
    logic          found_reg;
    logic [SW-1:0] best_reg;
    logic [31:0]   best_lat_reg;

    // result registers
    logic [1:0]             status_reg;
    logic [ChosenWidth-1:0] chosen_reg;
    logic [63:0]            total_reg;

    logic [31:0]   cur_lat;
    logic          fits;
    logic          cand;
    logic          found_next;
    logic [SW-1:0] best_next;
    logic [31:0]   best_lat_next;
    logic          any_free;
    logic [SW-1:0] free_idx;
    logic [SW-1:0] slot_idx;
    logic          res_bad;
    logic [63:0]   res_sum;
    logic [3:0]    free_w;
    logic [3:0]    best_w;
    logic          do_add;
    logic          do_res;

    logic [1:0]             status_next;
    logic [ChosenWidth-1:0] chosen_next;
    logic [63:0]            total_next;

    assign dp_st.is_pick   = (cmd_reg == CMD_PICK);
    assign dp_st.scan_last = (ptr_reg == SW'(SLOT_COUNT - 1));

    // one slot of the pick scan; doubled latency kept at 33 bits
    always_comb
    begin
        cur_lat       = lat_mem[ptr_reg];
        fits          = ({cur_lat, 1'b0} <= {1'b0, idle_reg});
        cand          = valid_reg[ptr_reg] && fits && (!found_reg || cur_lat > best_lat_reg);
        found_next    = found_reg || cand;
        best_next     = cand ? ptr_reg : best_reg;
        best_lat_next = cand ? cur_lat : best_lat_reg;
    end

    // lowest free slot
    always_comb
    begin
        any_free = 1'b0;
        free_idx = '0;
        for (int i = SLOT_COUNT - 1; i >= 0; i--)
        begin
            if (!valid_reg[i])
            begin
                any_free = 1'b1;
                free_idx = SW'(i);
            end
        end
    end

    assign slot_idx = slot_reg[SW-1:0];
    assign res_bad  = ({1'b0, slot_reg} >= 5'(SLOT_COUNT)) || !valid_reg[slot_idx];
    assign res_sum  = res_mem[slot_idx] + dur_reg;
    assign free_w   = 4'(free_idx);
    assign best_w   = 4'(best_next);

    assign do_add = cmd.finish && (cmd_reg == CMD_ADD) && any_free;
    assign do_res = cmd.finish && (cmd_reg == CMD_RES) && !res_bad;

    always_comb
    begin
        status_next = ST_BAD;
        chosen_next = '0;
        total_next  = '0;
        case (cmd_reg)
            CMD_ADD:
            begin
                if (any_free)
                begin
                    status_next = ST_OK;
                    chosen_next = free_w[ChosenWidth-1:0];
                end
                else
                    status_next = ST_FULL;
            end
            CMD_PICK:
            begin
                if (found_next)
                begin
                    status_next = ST_OK;
                    chosen_next = best_w[ChosenWidth-1:0];
                end
                else
                    status_next = ST_NONE;
            end
            CMD_RES:
            begin
                if (!res_bad)
                begin
                    status_next = ST_OK;
                    total_next  = res_sum;
                end
            end
            default:
            begin
                status_next = ST_BAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            ptr_reg   <= '0;
            found_reg <= 1'b0;
        end
        else
        begin
            if (do_add)
                valid_reg[free_idx] <= 1'b1;
            if (cmd.load)
            begin
                ptr_reg   <= '0;
                found_reg <= 1'b0;
            end
            else if (cmd.step && dp_st.is_pick)
            begin
                ptr_reg   <= ptr_reg + SW'(1);
                found_reg <= found_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_add)
        begin
            lat_mem[free_idx] <= lat_in_reg;
            res_mem[free_idx] <= '0;
        end
        else if (do_res)
            res_mem[slot_idx] <= res_sum;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            cmd_reg    <= command;
            lat_in_reg <= exit_latency;
            idle_reg   <= predicted_idle;
            slot_reg   <= slot;
            dur_reg    <= duration;
        end
        if (cmd.step && dp_st.is_pick)
        begin
            best_reg     <= best_next;
            best_lat_reg <= best_lat_next;
        end
        if (cmd.finish)
        begin
            status_reg <= status_next;
            chosen_reg <= chosen_next;
            total_reg  <= total_next;
        end
    end

    assign status          = status_reg;
    assign chosen_slot     = chosen_reg;
    assign residency_total = total_reg;

endmodule

// File: test/idle_state_selector_check.sv
`timescale 1ns / 100ps

module idle_state_selector_check
    import iss_pkg::*;
#(
    parameter int SLOT_COUNT = 8
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        busy,
    input  logic [1:0]  command,
    input  logic [31:0] exit_latency,
    input  logic [31:0] predicted_idle,
    input  logic [3:0]  slot,
    input  logic [63:0] duration,
    input  logic        done,
    input  logic [1:0]  status,
    input  logic [2:0]  chosen_slot,
    input  logic [63:0] residency_total,
    output int          pending,
    output int          fails
);

    localparam int TableDepth = 16;

    typedef struct packed {
        status_t                status;
        logic [ChosenWidth-1:0] chosen;
        logic [63:0]            total;
    } selector_result_t;

    // shadow copy of the idle state table
    logic        slot_used [TableDepth];
    logic [31:0] slot_lat [TableDepth];
    logic [63:0] slot_res [TableDepth];

    selector_result_t awaited_results [$];
    selector_result_t want;
    int mismatch_count = 0;
    int outstanding = 0;

    assign pending = outstanding;
    assign fails = mismatch_count;

    task automatic report(input string what);
        mismatch_count++;
        if (mismatch_count <= 40)
        begin
            $display("mismatch at %0t: %s", $time, what);
        end
    endtask

    function automatic selector_result_t selector_outcome(
        input logic [1:0]  cmd,
        input logic [31:0] lat,
        input logic [31:0] idle,
        input logic [3:0]  sl,
        input logic [63:0] dur
    );
        selector_result_t r;
        logic found;
        int best;
        r.status = ST_OK;
        r.chosen = '0;
        r.total = '0;
        found = 1'b0;
        best = 0;
        case (cmd)
            CMD_ADD:
            begin
                r.status = ST_FULL;
                for (int i = 0; i < SLOT_COUNT; i++)
                begin
                    if (!found && !slot_used[i])
                    begin
                        found = 1'b1;
                        slot_used[i] = 1'b1;
                        slot_lat[i] = lat;
                        slot_res[i] = '0;
                        r.status = ST_OK;
                        r.chosen = ChosenWidth'(i);
                    end
                end
            end
            CMD_PICK:
            begin
                for (int i = 0; i < SLOT_COUNT; i++)
                begin
                    // doubled latency held at 33 bits, no wrap
                    if (slot_used[i] && {slot_lat[i], 1'b0} <= {1'b0, idle})
                    begin
                        if (!found || slot_lat[i] > slot_lat[best])
                        begin
                            best = i;
                            found = 1'b1;
                        end
                    end
                end
                if (found)
                begin
                    r.chosen = ChosenWidth'(best);
                end
                else
                begin
                    r.status = ST_NONE;
                end
            end
            CMD_RES:
            begin
                if (int'(sl) >= SLOT_COUNT || !slot_used[sl])
                begin
                    r.status = ST_BAD;
                end
                else
                begin
                    slot_res[sl] = slot_res[sl] + dur;
                    r.total = slot_res[sl];
                end
            end
            default:
            begin
                r.status = ST_BAD;
            end
        endcase
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < TableDepth; i++)
            begin
                slot_used[i] = 1'b0;
                slot_lat[i] = '0;
                slot_res[i] = '0;
            end
            awaited_results.delete();
            outstanding <= 0;
        end
        else
        begin
            // results first: a new item may be taken in the same cycle as a result
            if (done === 1'b1)
            begin
                if (awaited_results.size() == 0)
                begin
                    report("result with no item outstanding");
                end
                else
                begin
                    want = awaited_results.pop_front();
                    if (status !== want.status)
                    begin
                        report($sformatf("status %0d, expected %s", status,
                                         want.status.name()));
                    end
                    if (chosen_slot !== want.chosen)
                    begin
                        report($sformatf("chosen_slot %0d, expected %0d", chosen_slot,
                                         want.chosen));
                    end
                    if (residency_total !== want.total)
                    begin
                        report($sformatf("residency_total %h, expected %h",
                                         residency_total, want.total));
                    end
                end
            end
            if (start === 1'b1 && busy === 1'b0)
            begin
                awaited_results.push_back(selector_outcome(command, exit_latency,
                                                           predicted_idle, slot,
                                                           duration));
            end
            outstanding <= awaited_results.size();
        end
    end

endmodule

// File: test/idle_state_selector_test.sv
`timescale 1ns / 100ps

module idle_state_selector_test
    import iss_pkg::*;
();

    localparam int SLOT_COUNT = 8;
    localparam int RANDOM_ITEMS = 1630;
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic [1:0]  command = '0;
    logic [31:0] exit_latency = '0;
    logic [31:0] predicted_idle = '0;
    logic [3:0]  slot = '0;
    logic [63:0] duration = '0;
    logic        busy;
    logic        done;
    logic [1:0]  status;
    logic [2:0]  chosen_slot;
    logic [63:0] residency_total;
    int          pending;
    int          fails;

    int burst_left = 0;
    int sent_adds = 0;
    int sent_picks = 0;
    int sent_res = 0;
    int sent_other = 0;
    // latencies in slot order, as adds always take the lowest free slot
    logic [31:0] added_latency [$];

    always #6 clk = ~clk;

    idle_state_selector #(.SLOT_COUNT(SLOT_COUNT)) dut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .command(command),
        .exit_latency(exit_latency),
        .predicted_idle(predicted_idle),
        .slot(slot),
        .duration(duration),
        .done(done),
        .status(status),
        .chosen_slot(chosen_slot),
        .residency_total(residency_total)
    );

    idle_state_selector_check #(.SLOT_COUNT(SLOT_COUNT)) outcome_check (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .command(command),
        .exit_latency(exit_latency),
        .predicted_idle(predicted_idle),
        .slot(slot),
        .duration(duration),
        .done(done),
        .status(status),
        .chosen_slot(chosen_slot),
        .residency_total(residency_total),
        .pending(pending),
        .fails(fails)
    );

    task automatic issue(
        input logic [1:0]  cmd,
        input logic [31:0] lat,
        input logic [31:0] idle,
        input logic [3:0]  sl,
        input logic [63:0] dur
    );
        start <= 1'b1;
        command <= cmd;
        exit_latency <= lat;
        predicted_idle <= idle;
        slot <= sl;
        duration <= dur;
        @(posedge clk);
        while (busy)
        begin
            @(posedge clk);
        end
        case (cmd)
            CMD_ADD:  sent_adds++;
            CMD_PICK: sent_picks++;
            CMD_RES:  sent_res++;
            default:  sent_other++;
        endcase
        if (cmd == CMD_ADD && added_latency.size() < SLOT_COUNT)
        begin
            added_latency.push_back(lat);
        end
        if (burst_left > 0)
        begin
            burst_left--;
        end
        else
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                    : $urandom_range(0, 8);
        end
    endtask

    task automatic drain();
        start <= 1'b0;
        do
        begin
            @(posedge clk);
        end
        while (pending != 0);
    endtask

    task automatic random_item();
        int kind;
        int k;
        logic [1:0]  cmd;
        logic [31:0] lat;
        logic [31:0] idle;
        logic [3:0]  sl;
        logic [63:0] dur;
        logic [32:0] doubled;
        kind = $urandom_range(0, 99);
        lat = $urandom();
        idle = $urandom();
        sl = 4'($urandom_range(0, 15));
        dur = {$urandom(), $urandom()};
        if (kind < 12)
        begin
            cmd = CMD_ADD;
        end
        else if (kind < 60)
        begin
            cmd = CMD_PICK;
        end
        else if (kind < 95)
        begin
            cmd = CMD_RES;
        end
        else
        begin
            cmd = CMD_UNUSED;
        end
        case ($urandom_range(0, 3))
            0: lat = $urandom_range(0, 1000);
            1: lat = 32'hFFFF_FFFF - $urandom_range(0, 3);
            2:
            begin
                // repeat a stored latency to make ties
                if (added_latency.size() > 0)
                begin
                    lat = added_latency[$urandom_range(0, added_latency.size() - 1)];
                end
            end
            default: ;
        endcase
        // aim most picks at the edge of a stored latency
        if (added_latency.size() > 0 && $urandom_range(0, 9) < 6)
        begin
            k = $urandom_range(0, added_latency.size() - 1);
            doubled = {added_latency[k], 1'b0};
            if (doubled[32])
            begin
                idle = 32'hFFFF_FFFF - $urandom_range(0, 1);
            end
            else
            begin
                idle = doubled[31:0] + $urandom_range(0, 2) - 1;
            end
        end
        else if ($urandom_range(0, 3) == 0)
        begin
            idle = $urandom_range(0, 2500);
        end
        if ($urandom_range(0, 4) != 0)
        begin
            sl = 4'($urandom_range(0, SLOT_COUNT - 1));
        end
        if ($urandom_range(0, 3) == 0)
        begin
            dur = 64'($urandom_range(0, 5000));
        end
        issue(cmd, lat, idle, sl, dur);
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        issue(CMD_PICK, '0, 32'hFFFF_FFFF, '0, '0);          // empty table
        issue(CMD_RES, '0, '0, 4'd0, 64'd5);                 // slot never added
        issue(CMD_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'hF, '1);
        issue(CMD_ADD, 32'hFFFF_FFFF, '0, '0, '0);
        // doubled latency past 32 bits must not qualify
        issue(CMD_PICK, '0, 32'hFFFF_FFFF, '0, '0);
        issue(CMD_ADD, 32'h8000_0000, '0, '0, '0);
        issue(CMD_ADD, 32'h7FFF_FFFF, '0, '0, '0);
        issue(CMD_ADD, 32'h7FFF_FFFF, '0, '0, '0);
        issue(CMD_PICK, '0, 32'hFFFF_FFFF, '0, '0);          // tie, lowest slot wins
        issue(CMD_PICK, '0, 32'hFFFF_FFFD, '0, '0);
        issue(CMD_ADD, 32'd0, '0, '0, '0);
        issue(CMD_PICK, '0, 32'd0, '0, '0);
        issue(CMD_ADD, 32'd100, '0, '0, '0);
        issue(CMD_PICK, '0, 32'd200, '0, '0);                // exactly twice
        issue(CMD_PICK, '0, 32'd199, '0, '0);
        issue(CMD_RES, '0, '0, 4'd0, 64'hFFFF_FFFF_FFFF_FFFF);
        issue(CMD_RES, '0, '0, 4'd0, 64'd2);                 // wraps round
        issue(CMD_RES, '0, '0, 4'd15, 64'd7);
        issue(CMD_RES, '0, '0, 4'd8, 64'd7);
        issue(CMD_RES, '0, '0, 4'd6, 64'd7);                 // free slot
        drain();

        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i == RANDOM_ITEMS / 2)
            begin
                drain();
            end
            random_item();
        end

        drain();
        repeat (4 * SLOT_COUNT) @(posedge clk);
        $display("covered %0d items: %0d add, %0d pick, %0d residency, %0d unknown command",
                 sent_adds + sent_picks + sent_res + sent_other, sent_adds, sent_picks,
                 sent_res, sent_other);
        $display("table filled to %0d slots, with sender gaps, long bursts and drains",
                 added_latency.size());
        if (fails == 0)
        begin
            $display("idle_state_selector regression: pass");
        end
        else
        begin
            $display("idle_state_selector regression: fail");
        end
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("timeout with %0d items outstanding", pending);
        $display("idle_state_selector regression: fail");
        $finish;
    end

endmodule

// File: sim.f
+incdir+sv
sv/iss_pkg.sv
sv/iss_ctrl.sv
sv/iss_dp.sv
sv/idle_state_selector.sv
test/idle_state_selector_check.sv
test/idle_state_selector_test.sv
